>>> design/ttlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled texture layout converter package
// Shared widths, register indexes, reset values and payload types.
// ----------------------------------------------------------------------------
package ttlc_pkg;

    localparam int COORD_W    = 10;
    localparam int CHAN_W     = 8;
    localparam int ADDR_W     = 22;
    localparam int DATA_W     = 16;
    localparam int CFG_DIM_W  = 11;
    localparam int CFG_BPP_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // A tile index shifted left by five (32-byte tiles) covers the address.
    localparam int TILE_IDX_W = ADDR_W - 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_FORMAT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BYTES_PER = 2'd3;

    localparam logic                 FMT_INDEX = 1'b0;
    localparam logic                 FMT_RGBA  = 1'b1;

    localparam logic                 RST_TILE_FORMAT  = FMT_RGBA;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd1;
    localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd1;
    localparam logic [CFG_BPP_W-1:0] RST_BPP          = 3'd4;

    localparam logic [CHAN_W-1:0]    FILL_BYTE = 8'hFF;

    typedef struct packed {
        logic                 tile_format;
        logic [CFG_DIM_W-1:0] image_width;
        logic [CFG_DIM_W-1:0] image_height;
        logic [CFG_BPP_W-1:0] source_bytes_per_texel;
    } t_ttlc_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] texel_x;
        logic [COORD_W-1:0] texel_y;
        logic [CHAN_W-1:0]  chan_red;
        logic [CHAN_W-1:0]  chan_green;
        logic [CHAN_W-1:0]  chan_blue;
        logic [CHAN_W-1:0]  chan_alpha;
    } t_ttlc_texel;

    typedef struct packed {
        logic [ADDR_W-1:0] first_address;
        logic [DATA_W-1:0] first_data;
        logic [ADDR_W-1:0] second_address;
        logic [DATA_W-1:0] second_data;
        logic              two_byte_writes;
        logic              outside_grid;
    } t_ttlc_result;

endpackage

>>> design/ttlc_texel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texel input channel
// Valid/ready channel carrying one texel position and its source bytes.
// ----------------------------------------------------------------------------
interface ttlc_texel_if
    import ttlc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] texel_x;
    logic [COORD_W-1:0] texel_y;
    logic [CHAN_W-1:0]  chan_red;
    logic [CHAN_W-1:0]  chan_green;
    logic [CHAN_W-1:0]  chan_blue;
    logic [CHAN_W-1:0]  chan_alpha;

    modport source (
        output valid, texel_x, texel_y, chan_red, chan_green, chan_blue, chan_alpha,
        input  ready
    );

    modport sink (
        input  valid, texel_x, texel_y, chan_red, chan_green, chan_blue, chan_alpha,
        output ready
    );
endinterface

>>> design/ttlc_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tiled write result channel
// Valid/ready channel carrying the tiled store addresses and data of a texel.
// ----------------------------------------------------------------------------
interface ttlc_result_if
    import ttlc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] first_address;
    logic [DATA_W-1:0] first_data;
    logic [ADDR_W-1:0] second_address;
    logic [DATA_W-1:0] second_data;
    logic              two_byte_writes;
    logic              outside_grid;

    modport source (
        output valid, first_address, first_data, second_address, second_data,
               two_byte_writes, outside_grid,
        input  ready
    );

    modport sink (
        input  valid, first_address, first_data, second_address, second_data,
               two_byte_writes, outside_grid,
        output ready
    );
endinterface

>>> design/ttlc_swizzle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tile swizzle datapath
// Maps one padded-grid texel to its tiled byte addresses and write data.
// ----------------------------------------------------------------------------
module ttlc_swizzle
    import ttlc_pkg::*;
#(
    parameter int MAX_DIMENSION = 1024
) (
    input  t_ttlc_cfg    i_cfg,
    input  t_ttlc_texel  i_texel,
    output t_ttlc_result o_result
);

    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CW    = (DIM_W > CFG_DIM_W) ? DIM_W : CFG_DIM_W;
    localparam logic [CW-1:0] MAX_DIM = CW'(MAX_DIMENSION);

    logic                  rgba;
    logic [CW-1:0]         w;
    logic [CW-1:0]         h;
    logic [CW:0]           w_up4;
    logic [CW:0]           w_up8;
    logic [CW:0]           h_up4;
    logic [CW-2:0]         tiles_x;
    logic [CW:0]           grid_w;
    logic [CW:0]           grid_h;
    logic                  outside;
    logic                  in_image;
    logic [COORD_W-3:0]    tx;
    logic [COORD_W-3:0]    ty;
    logic [2:0]            col;
    logic [1:0]            row;
    logic [3:0]            slot;
    logic [CW+COORD_W-5:0] prod;
    logic [TILE_IDX_W-1:0] tile;
    logic [CHAN_W-1:0]     r;
    logic [CHAN_W-1:0]     g;
    logic [CHAN_W-1:0]     b;
    logic [CHAN_W-1:0]     a;

    always_comb begin
        rgba = (i_cfg.tile_format == FMT_RGBA);

        // Dimensions saturate at the largest supported image edge.
        w = (CW'(i_cfg.image_width) > MAX_DIM) ? MAX_DIM : CW'(i_cfg.image_width);
        h = (CW'(i_cfg.image_height) > MAX_DIM) ? MAX_DIM : CW'(i_cfg.image_height);

        w_up4 = {1'b0, w} + (CW+1)'(3);
        w_up8 = {1'b0, w} + (CW+1)'(7);
        h_up4 = {1'b0, h} + (CW+1)'(3);

        tiles_x = rgba ? w_up4[CW:2] : {1'b0, w_up8[CW:3]};
        grid_w  = rgba ? {w_up4[CW:2], 2'b00} : {w_up8[CW:3], 3'b000};
        grid_h  = {h_up4[CW:2], 2'b00};

        outside  = ((CW+1)'(i_texel.texel_x) >= grid_w) ||
                   ((CW+1)'(i_texel.texel_y) >= grid_h);
        in_image = (CW'(i_texel.texel_x) < w) && (CW'(i_texel.texel_y) < h);

        tx   = rgba ? i_texel.texel_x[COORD_W-1:2] : {1'b0, i_texel.texel_x[COORD_W-1:3]};
        col  = rgba ? {1'b0, i_texel.texel_x[1:0]} : i_texel.texel_x[2:0];
        ty   = i_texel.texel_y[COORD_W-1:2];
        row  = i_texel.texel_y[1:0];
        slot = {row, col[1:0]};

        prod = (CW+COORD_W-4)'(ty) * (CW+COORD_W-4)'(tiles_x);
        tile = prod[TILE_IDX_W-1:0] + TILE_IDX_W'(tx);

        // Padding texels carry zero in every channel; absent channels read full.
        if (in_image) begin
            r = i_texel.chan_red;
            g = (i_cfg.source_bytes_per_texel >= 3'd2) ? i_texel.chan_green : FILL_BYTE;
            b = (i_cfg.source_bytes_per_texel >= 3'd3) ? i_texel.chan_blue  : FILL_BYTE;
            a = (i_cfg.source_bytes_per_texel >= 3'd4) ? i_texel.chan_alpha : FILL_BYTE;
        end else begin
            r = '0;
            g = '0;
            b = '0;
            a = '0;
        end

        o_result                 = '0;
        o_result.two_byte_writes = rgba;
        o_result.outside_grid    = outside;
        if (!outside) begin
            if (rgba) begin
                o_result.first_address  = {tile[TILE_IDX_W-2:0], 1'b0, slot, 1'b0};
                o_result.first_data     = {a, r};
                o_result.second_address = {tile[TILE_IDX_W-2:0], 1'b1, slot, 1'b0};
                o_result.second_data    = {g, b};
            end else begin
                o_result.first_address = {tile, row, col};
                o_result.first_data    = {{(DATA_W-CHAN_W){1'b0}}, r};
            end
        end
    end

endmodule

>>> design/texture_tile_layout_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture tile layout converter
// Converts padded-grid texels to CI8 or RGBA8 tiled store writes.
// ----------------------------------------------------------------------------
// An accepted texel passes through the input register, then through the result
// register after the swizzle datapath, before its result is valid.
// Throughput: one texel per cycle; both stages advance together whenever the
// result register is empty or its result is taken.
// Reset (synchronous, active low) empties both stages and restores the
// configuration registers to their power-on values.
module texture_tile_layout_converter
    import ttlc_pkg::*;
#(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ttlc_texel_if.sink            i_texel,
    ttlc_result_if.source         o_result
);

    t_ttlc_cfg    r_cfg;
    logic         r_s1_valid;
    t_ttlc_texel  r_s1;
    logic         r_s2_valid;
    t_ttlc_result r_s2;
    t_ttlc_result n_s2;
    logic         s2_en;
    logic         s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_format            <= RST_TILE_FORMAT;
            r_cfg.image_width            <= RST_IMAGE_WIDTH;
            r_cfg.image_height           <= RST_IMAGE_HEIGHT;
            r_cfg.source_bytes_per_texel <= RST_BPP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TILE_FORMAT:  r_cfg.tile_format  <= i_cfg_data[0];
                CFG_IMAGE_WIDTH:  r_cfg.image_width  <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg.image_height <= i_cfg_data[CFG_DIM_W-1:0];
                CFG_SOURCE_BYTES_PER:
                    r_cfg.source_bytes_per_texel <= i_cfg_data[CFG_BPP_W-1:0];
                default: ;
            endcase
        end
    end

    assign s2_en = !r_s2_valid || o_result.ready;
    assign s1_en = !r_s1_valid || s2_en;
    assign i_texel.ready = s1_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_valid <= i_texel.valid;
            end
            if (s2_en) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_en && i_texel.valid) begin
            r_s1.texel_x    <= i_texel.texel_x;
            r_s1.texel_y    <= i_texel.texel_y;
            r_s1.chan_red   <= i_texel.chan_red;
            r_s1.chan_green <= i_texel.chan_green;
            r_s1.chan_blue  <= i_texel.chan_blue;
            r_s1.chan_alpha <= i_texel.chan_alpha;
        end
        if (s2_en && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    ttlc_swizzle #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_swizzle (
        .i_cfg   (r_cfg),
        .i_texel (r_s1),
        .o_result(n_s2)
    );

    assign o_result.valid           = r_s2_valid;
    assign o_result.first_address   = r_s2.first_address;
    assign o_result.first_data      = r_s2.first_data;
    assign o_result.second_address  = r_s2.second_address;
    assign o_result.second_data     = r_s2.second_data;
    assign o_result.two_byte_writes = r_s2.two_byte_writes;
    assign o_result.outside_grid    = r_s2.outside_grid;

`ifndef NO_ASSERTIONS
    // A position beyond the padded grid produces no write address or data.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.outside_grid |->
            o_result.first_address == '0 && o_result.first_data == '0 &&
            o_result.second_address == '0 && o_result.second_data == '0)
        else $error("outside-grid transaction carries nonzero write fields");

    // Index tiles never carry a second write.
    a_index_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.two_byte_writes |->
            o_result.second_address == '0 && o_result.second_data == '0)
        else $error("index-mode transaction carries a second write");

    // The green-blue pair sits 32 bytes after the alpha-red pair.
    a_pair_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.two_byte_writes && !o_result.outside_grid |->
            o_result.second_address == o_result.first_address + ADDR_W'(32))
        else $error("second pair is not 32 bytes after the first");

    // A texel taken while both stages are full and stalled would be lost.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s2_valid && !o_result.ready |-> !i_texel.ready)
        else $error("texel accepted while the pipeline is full and stalled");

    // After reset the result channel is empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
`endif

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture tile layout converter testbench
// Streams texel positions through the converter under a series of tile
// formats, image sizes and source byte counts. Every result transaction is
// checked field by field against a behavioral swizzle computed in the bench.
// Both channel sides idle at random, and the result side holds off for long
// stretches so that the converter fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
    import ttlc_pkg::*;

    localparam int MAX_DIM     = 1024;
    localparam int HOLD_CYCLES = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ttlc_texel_if  texel_ch ();
    ttlc_result_if result_ch ();

    texture_tile_layout_converter #(
        .MAX_DIMENSION(MAX_DIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_texel    (texel_ch),
        .o_result   (result_ch)
    );

    t_ttlc_texel  pending_texels[$];
    t_ttlc_result expected_writes[$];
    t_ttlc_cfg    cfg_shadow;
    t_ttlc_texel  on_offer;
    int           texels_sent    = 0;
    int           writes_checked = 0;
    int           hold_left      = 0;
    int           error_count    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Expected tiled store writes for one texel under the given register values.
    function automatic t_ttlc_result tiled_write_for(t_ttlc_texel t, t_ttlc_cfg c);
        int unsigned  w, h, tile_w, tiles_x, tiles_y, tile, slot, col, row;
        logic [7:0]   r, g, b, a;
        bit           rgba, outside, in_image;
        t_ttlc_result res;
        res      = '0;
        w        = (c.image_width > MAX_DIM) ? MAX_DIM : c.image_width;
        h        = (c.image_height > MAX_DIM) ? MAX_DIM : c.image_height;
        rgba     = (c.tile_format == FMT_RGBA);
        tile_w   = rgba ? 4 : 8;
        tiles_x  = (w + tile_w - 1) / tile_w;
        tiles_y  = (h + 3) / 4;
        outside  = (t.texel_x >= tiles_x * tile_w) || (t.texel_y >= tiles_y * 4);
        in_image = (t.texel_x < w) && (t.texel_y < h);
        res.two_byte_writes = rgba;
        res.outside_grid    = outside;
        if (!outside) begin
            col  = t.texel_x % tile_w;
            row  = t.texel_y % 4;
            tile = (t.texel_y / 4) * tiles_x + t.texel_x / tile_w;
            if (rgba) begin
                slot = row * 4 + col;
                {r, g, b, a} = '0;
                if (in_image) begin
                    r = t.chan_red;
                    g = (c.source_bytes_per_texel >= 2) ? t.chan_green : FILL_BYTE;
                    b = (c.source_bytes_per_texel >= 3) ? t.chan_blue  : FILL_BYTE;
                    a = (c.source_bytes_per_texel >= 4) ? t.chan_alpha : FILL_BYTE;
                end
                res.first_address  = ADDR_W'(tile * 64 + slot * 2);
                res.first_data     = {a, r};
                res.second_address = ADDR_W'(tile * 64 + 32 + slot * 2);
                res.second_data    = {g, b};
            end else begin
                res.first_address = ADDR_W'(tile * 32 + row * 8 + col);
                res.first_data    = in_image ? DATA_W'(t.chan_red) : '0;
            end
        end
        return res;
    endfunction

    function automatic t_ttlc_cfg make_cfg(logic fmt, int w, int h, int bpp);
        t_ttlc_cfg c;
        c.tile_format            = fmt;
        c.image_width            = CFG_DIM_W'(w);
        c.image_height           = CFG_DIM_W'(h);
        c.source_bytes_per_texel = CFG_BPP_W'(bpp);
        return c;
    endfunction

    // Mostly inside the padded grid, some around its edge, the rest anywhere.
    function automatic logic [COORD_W-1:0] pick_coord(int extent);
        int roll, v;
        roll = $urandom_range(99, 0);
        if (extent > 0 && roll < 70) begin
            v = $urandom_range(extent - 1, 0);
        end else if (roll < 85) begin
            v = extent + int'($urandom_range(4, 0)) - 2;
            v = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
        end else begin
            v = $urandom_range(1023, 0);
        end
        return COORD_W'(v);
    endfunction

    function automatic logic [CHAN_W-1:0] pick_byte();
        int roll;
        roll = $urandom_range(9, 0);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return CHAN_W'($urandom_range(255, 0));
    endfunction

    task automatic queue_texel(int x, int y, int r, int g, int b, int a);
        t_ttlc_texel t;
        t.texel_x    = COORD_W'(x);
        t.texel_y    = COORD_W'(y);
        t.chan_red   = CHAN_W'(r);
        t.chan_green = CHAN_W'(g);
        t.chan_blue  = CHAN_W'(b);
        t.chan_alpha = CHAN_W'(a);
        pending_texels.push_back(t);
    endtask

    task automatic queue_random_texel();
        int unsigned w, h, tile_w;
        t_ttlc_texel t;
        w      = (cfg_shadow.image_width > MAX_DIM) ? MAX_DIM : cfg_shadow.image_width;
        h      = (cfg_shadow.image_height > MAX_DIM) ? MAX_DIM : cfg_shadow.image_height;
        tile_w = (cfg_shadow.tile_format == FMT_RGBA) ? 4 : 8;
        t.texel_x    = pick_coord(((w + tile_w - 1) / tile_w) * tile_w);
        t.texel_y    = pick_coord(((h + 3) / 4) * 4);
        t.chan_red   = pick_byte();
        t.chan_green = pick_byte();
        t.chan_blue  = pick_byte();
        t.chan_alpha = pick_byte();
        pending_texels.push_back(t);
    endtask

    // Registers change only while nothing is queued or in flight.
    task automatic apply_format(t_ttlc_cfg c);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TILE_FORMAT;
        i_cfg_data  <= CFG_DATA_W'(c.tile_format);
        @(posedge i_clk);
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= CFG_DATA_W'(c.image_width);
        @(posedge i_clk);
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= CFG_DATA_W'(c.image_height);
        @(posedge i_clk);
        i_cfg_index <= CFG_SOURCE_BYTES_PER;
        i_cfg_data  <= CFG_DATA_W'(c.source_bytes_per_texel);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_shadow = c;
        @(negedge i_clk);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pending_texels.size() != 0 || texel_ch.valid || expected_writes.size() != 0);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic check_field(string field, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            error_count++;
        end
    endtask

    // Texel driver: predicts each transaction as it is accepted.
    always @(posedge i_clk) begin : texel_driver
        bit idle;
        t_ttlc_texel upcoming;
        if (!i_rst_n) begin
            texel_ch.valid <= 1'b0;
        end else begin
            if (texel_ch.valid && texel_ch.ready) begin
                expected_writes.push_back(tiled_write_for(on_offer, cfg_shadow));
                texels_sent <= texels_sent + 1;
            end
            if (!texel_ch.valid || texel_ch.ready) begin
                idle = !(texels_sent >= 500 && texels_sent < 700)
                       && ($urandom_range(99, 0) < 11);
                if (pending_texels.size() != 0 && !idle) begin
                    upcoming = pending_texels.pop_front();
                    on_offer            <= upcoming;
                    texel_ch.valid      <= 1'b1;
                    texel_ch.texel_x    <= upcoming.texel_x;
                    texel_ch.texel_y    <= upcoming.texel_y;
                    texel_ch.chan_red   <= upcoming.chan_red;
                    texel_ch.chan_green <= upcoming.chan_green;
                    texel_ch.chan_blue  <= upcoming.chan_blue;
                    texel_ch.chan_alpha <= upcoming.chan_alpha;
                end else begin
                    texel_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and ready generator.
    always @(posedge i_clk) begin : result_monitor
        bit start_hold;
        t_ttlc_result want;
        start_hold = 1'b0;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            hold_left       <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (expected_writes.size() == 0) begin
                    $error("result transaction with no expected texel");
                    error_count++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("first_address", want.first_address,
                                result_ch.first_address);
                    check_field("first_data", want.first_data, result_ch.first_data);
                    check_field("second_address", want.second_address,
                                result_ch.second_address);
                    check_field("second_data", want.second_data, result_ch.second_data);
                    check_field("two_byte_writes", want.two_byte_writes,
                                result_ch.two_byte_writes);
                    check_field("outside_grid", want.outside_grid, result_ch.outside_grid);
                end
                writes_checked <= writes_checked + 1;
                start_hold = (writes_checked + 1 == 250) || (writes_checked + 1 == 777);
            end
            if (start_hold) begin
                result_ch.ready <= 1'b0;
                hold_left       <= HOLD_CYCLES;
            end else if (hold_left != 0) begin
                result_ch.ready <= 1'b0;
                hold_left       <= hold_left - 1;
            end else begin
                result_ch.ready <= (writes_checked >= 500 && writes_checked < 700)
                                   || ($urandom_range(99, 0) >= 11);
            end
        end
    end

    initial begin : stimulus
        t_ttlc_cfg random_plan[$];
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_index          = CFG_TILE_FORMAT;
        i_cfg_data           = '0;
        texel_ch.valid       = 1'b0;
        texel_ch.texel_x     = '0;
        texel_ch.texel_y     = '0;
        texel_ch.chan_red    = '0;
        texel_ch.chan_green  = '0;
        texel_ch.chan_blue   = '0;
        texel_ch.chan_alpha  = '0;
        result_ch.ready      = 1'b0;
        on_offer             = '0;
        cfg_shadow = make_cfg(RST_TILE_FORMAT, int'(RST_IMAGE_WIDTH), int'(RST_IMAGE_HEIGHT),
                              int'(RST_BPP));
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Power-on registers: a single RGBA texel padded out to one tile.
        queue_texel(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(0, 0, 0, 0, 0, 0);
        queue_texel(0, 0, 8'h12, 8'h34, 8'h56, 8'h78);
        queue_texel(3, 3, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(2, 1, 8'hAA, 8'h55, 8'hAA, 8'h55);
        queue_texel(4, 0, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_texel(0, 4, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_texel(1023, 1023, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        drain();

        // Index tiles with an oversized width that saturates.
        apply_format(make_cfg(FMT_INDEX, 2047, 1024, 1));
        queue_texel(0, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(1023, 1023, 8'hFF, 0, 0, 0);
        queue_texel(1023, 0, 8'h80, 8'h01, 8'h02, 8'h03);
        queue_texel(0, 1023, 8'h01, 8'hFE, 8'hFD, 8'hFC);
        queue_texel(9, 5, 8'h5A, 8'hA5, 8'h5A, 8'hA5);
        drain();

        // A zero byte count reads red only; padding fills the tile out.
        apply_format(make_cfg(FMT_RGBA, 5, 9, 0));
        queue_texel(4, 8, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_texel(5, 8, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_texel(7, 11, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_texel(8, 0, 8'h11, 8'h22, 8'h33, 8'h44);
        queue_texel(0, 12, 8'h11, 8'h22, 8'h33, 8'h44);
        drain();

        // Empty grids: every position lies outside.
        apply_format(make_cfg(FMT_INDEX, 0, 7, 7));
        queue_texel(0, 0, 8'h77, 8'h66, 8'h55, 8'h44);
        queue_texel(5, 3, 8'h77, 8'h66, 8'h55, 8'h44);
        drain();
        apply_format(make_cfg(FMT_RGBA, 1024, 0, 3));
        queue_texel(0, 0, 8'h77, 8'h66, 8'h55, 8'h44);
        queue_texel(1023, 0, 8'h77, 8'h66, 8'h55, 8'h44);
        drain();

        // Byte counts above four behave like four.
        apply_format(make_cfg(FMT_RGBA, 6, 5, 6));
        queue_texel(5, 4, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        queue_texel(6, 0, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        queue_texel(7, 7, 8'h9A, 8'hBC, 8'hDE, 8'hF0);
        drain();

        random_plan.push_back(make_cfg(FMT_RGBA, 640, 480, 4));
        random_plan.push_back(make_cfg(FMT_INDEX, 13, 7, 1));
        random_plan.push_back(make_cfg(FMT_RGBA, 13, 7, 3));
        random_plan.push_back(make_cfg(FMT_RGBA, 5, 9, 2));
        random_plan.push_back(make_cfg(FMT_RGBA, 1024, 1024, 0));
        random_plan.push_back(make_cfg(FMT_RGBA, 2047, 1500, 7));
        random_plan.push_back(make_cfg(FMT_INDEX, 0, 5, 4));
        random_plan.push_back(make_cfg(FMT_RGBA, 7, 0, 5));
        random_plan.push_back(make_cfg(FMT_INDEX, 1024, 1024, 6));
        random_plan.push_back(make_cfg(FMT_INDEX, 100, 37, 2));
        random_plan.push_back(make_cfg(FMT_RGBA, 1, 1, 1));
        repeat (2) begin
            random_plan.push_back(make_cfg(1'($urandom_range(1, 0)),
                                           $urandom_range(1100, 1),
                                           $urandom_range(1100, 1), $urandom_range(7, 0)));
        end

        foreach (random_plan[i]) begin
            apply_format(random_plan[i]);
            repeat ($urandom_range(100, 70)) queue_random_texel();
            drain();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #200000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
